FILE: src/alxy_pkg.sv
// Shared types and constants for the framed ASCII x/y parser.
// Used by the front classifier, the token queue and the back parser.
package alxy_pkg;

    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int LEN_DIGITS = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_FEW     = 2'd2;
    localparam logic [1:0] ST_NO_DIG  = 2'd3;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_COMMA,
        CLS_PLUS,
        CLS_MINUS,
        CLS_M,
        CLS_P,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
    } t_tok;

endpackage

FILE: src/alxy_front.sv
// Front stage: accepts received bytes and classifies each into a token.
// Depends on alxy_pkg for the character constants and the token type.
module alxy_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  logic [7:0]    i_rx_byte,
    output logic          o_tok_valid,
    input  logic          i_tok_ready,
    output alxy_pkg::t_tok o_tok
);
    import alxy_pkg::*;

    logic r_valid;
    t_tok r_tok;
    t_tok n_tok;
    logic [7:0] w_diff;

    assign w_diff     = i_rx_byte - CH_ZERO;
    assign o_rx_ready = !r_valid || i_tok_ready;

    always_comb begin
        n_tok.digit = w_diff[3:0];
        if (i_rx_byte >= CH_ZERO && i_rx_byte <= CH_NINE) begin
            n_tok.cls = CLS_DIGIT;
        end else if (i_rx_byte == CH_COMMA) begin
            n_tok.cls = CLS_COMMA;
        end else if (i_rx_byte == CH_PLUS) begin
            n_tok.cls = CLS_PLUS;
        end else if (i_rx_byte == CH_MINUS) begin
            n_tok.cls = CLS_MINUS;
        end else if (i_rx_byte == CH_M) begin
            n_tok.cls = CLS_M;
        end else if (i_rx_byte == CH_P) begin
            n_tok.cls = CLS_P;
        end else begin
            n_tok.cls = CLS_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

endmodule

FILE: src/alxy_queue.sv
// Short token queue between the front classifier and the back parser.
// Depends on alxy_pkg for the token type.
module alxy_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  alxy_pkg::t_tok i_push_tok,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output alxy_pkg::t_tok o_pop_tok
);
    import alxy_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

FILE: src/alxy_back.sv
// Back stage: frame state machine, field parsing and the result register.
// Depends on alxy_pkg for the token type and the status codes.
module alxy_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tok_valid,
    output logic               o_tok_ready,
    input  alxy_pkg::t_tok     i_tok,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic signed [15:0] o_x_centi,
    output logic signed [15:0] o_y_centi,
    output logic [1:0]         o_frame_status
);
    import alxy_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT_M  = 4'b0001,
        PH_HUNT_P  = 4'b0010,
        PH_LENGTH  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    localparam logic [15:0] ACC_CLAMP = 16'd32768;

    t_phase             r_phase,   n_phase;
    logic [1:0]         r_lcnt,    n_lcnt;
    logic [13:0]        r_len,     n_len;
    logic [13:0]        r_left,    n_left;
    logic [2:0]         r_fnum,    n_fnum;
    logic [15:0]        r_acc,     n_acc;
    logic               r_neg,     n_neg;
    logic               r_dig,     n_dig;
    logic               r_has,     n_has;
    logic               r_stop,    n_stop;
    logic               r_ferr,    n_ferr;
    logic signed [15:0] r_held_x,  n_held_x;
    logic               r_res_valid;
    logic signed [15:0] r_x, r_y;
    logic [1:0]         r_status;

    logic               w_take;
    logic               w_emit;
    logic [1:0]         w_status;
    logic signed [15:0] w_y;
    logic [18:0]        w_acc_wide;

    function automatic logic signed [15:0] sat_value(input logic [15:0] mag, input logic neg);
        logic signed [15:0] v;
        if (neg) begin
            v = $signed(16'(~mag + 16'd1));
        end else if (mag > 16'd32767) begin
            v = 16'sd32767;
        end else begin
            v = $signed(mag);
        end
        return v;
    endfunction

    assign o_tok_ready = !r_res_valid || i_res_ready;
    assign w_take      = i_tok_valid && o_tok_ready;
    assign w_acc_wide  = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1) + 19'(i_tok.digit);

    always_comb begin
        n_phase  = r_phase;
        n_lcnt   = r_lcnt;
        n_len    = r_len;
        n_left   = r_left;
        n_fnum   = r_fnum;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_dig    = r_dig;
        n_has    = r_has;
        n_stop   = r_stop;
        n_ferr   = r_ferr;
        n_held_x = r_held_x;
        w_emit   = 1'b0;
        w_status = ST_OK;
        w_y      = '0;

        unique case (r_phase)
            PH_HUNT_M: begin
                if (i_tok.cls == CLS_M) begin
                    n_phase = PH_HUNT_P;
                end
            end
            PH_HUNT_P: begin
                if (i_tok.cls == CLS_P) begin
                    n_phase = PH_LENGTH;
                    n_lcnt  = '0;
                    n_len   = '0;
                end else if (i_tok.cls != CLS_M) begin
                    n_phase = PH_HUNT_M;
                end
            end
            PH_LENGTH: begin
                if (i_tok.cls != CLS_DIGIT) begin
                    w_emit   = 1'b1;
                    w_status = ST_BAD_LEN;
                    n_phase  = PH_HUNT_M;
                end else begin
                    n_len  = 14'((r_len << 3) + (r_len << 1)) + 14'(i_tok.digit);
                    n_lcnt = r_lcnt + 1'b1;
                    if (r_lcnt == 2'(LEN_DIGITS - 1)) begin
                        // Fourth digit: a new frame starts with everything cleared.
                        n_lcnt   = '0;
                        n_fnum   = '0;
                        n_ferr   = 1'b0;
                        n_held_x = '0;
                        n_acc    = '0;
                        n_neg    = 1'b0;
                        n_dig    = 1'b0;
                        n_has    = 1'b0;
                        n_stop   = 1'b0;
                        n_left   = n_len;
                        if (n_len == '0) begin
                            // Only field 0 exists, so the frame has too few fields.
                            w_emit   = 1'b1;
                            w_status = ST_FEW;
                            n_phase  = PH_HUNT_M;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (i_tok.cls == CLS_COMMA) begin
                    if (r_fnum == 3'd2) begin
                        n_held_x = sat_value(r_acc, r_neg);
                        n_ferr   = !r_dig;
                        n_acc    = '0;
                        n_neg    = 1'b0;
                        n_dig    = 1'b0;
                        n_has    = 1'b0;
                        n_stop   = 1'b0;
                        n_fnum   = 3'd3;
                    end else if (r_fnum == 3'd3) begin
                        // Field 3 keeps its value; later fields are only counted.
                        n_fnum = 3'd4;
                    end else if (r_fnum < 3'd2) begin
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_dig  = 1'b0;
                        n_has  = 1'b0;
                        n_stop = 1'b0;
                        n_fnum = r_fnum + 1'b1;
                    end
                end else if (r_fnum == 3'd2 || r_fnum == 3'd3) begin
                    if (!r_stop) begin
                        if (i_tok.cls == CLS_DIGIT) begin
                            n_acc = (w_acc_wide > 19'(ACC_CLAMP)) ? ACC_CLAMP
                                                                  : w_acc_wide[15:0];
                            n_dig = 1'b1;
                        end else if (!r_has && (i_tok.cls == CLS_PLUS ||
                                                i_tok.cls == CLS_MINUS)) begin
                            n_neg = (i_tok.cls == CLS_MINUS);
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                    n_has = 1'b1;
                end

                n_left = r_left - 1'b1;
                if (r_left <= 14'd1) begin
                    w_emit  = 1'b1;
                    n_phase = PH_HUNT_M;
                    w_y     = sat_value(n_acc, n_neg);
                    if (n_fnum < 3'd2) begin
                        w_status = ST_FEW;
                    end else if (n_fnum == 3'd2) begin
                        w_status = (n_has && !n_dig) ? ST_NO_DIG : ST_FEW;
                    end else if (n_ferr) begin
                        w_status = ST_NO_DIG;
                    end else if (n_fnum == 3'd3 && !n_has) begin
                        w_status = ST_FEW;
                    end else if (!n_dig) begin
                        w_status = ST_NO_DIG;
                    end else begin
                        w_status = ST_OK;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT_M;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT_M;
            r_lcnt      <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_fnum      <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_dig       <= 1'b0;
            r_has       <= 1'b0;
            r_stop      <= 1'b0;
            r_ferr      <= 1'b0;
            r_held_x    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase  <= n_phase;
                r_lcnt   <= n_lcnt;
                r_len    <= n_len;
                r_left   <= n_left;
                r_fnum   <= n_fnum;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_dig    <= n_dig;
                r_has    <= n_has;
                r_stop   <= n_stop;
                r_ferr   <= n_ferr;
                r_held_x <= n_held_x;
            end
            if (w_take && w_emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Values are forced to zero on any error status.
    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_status <= w_status;
            r_x      <= (w_status == ST_OK) ? n_held_x : 16'sd0;
            r_y      <= (w_status == ST_OK) ? w_y : 16'sd0;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_x_centi      = r_x;
    assign o_y_centi      = r_y;
    assign o_frame_status = r_status;

endmodule

FILE: src/ascii_length_framed_xy_parser.sv
// Framed ASCII x/y parser. One received byte is taken per clock cycle when
// the result side keeps up; the back parser handles one byte per cycle while
// its result register is free, and the QUEUE_DEPTH-entry token queue lets the
// two sides stall apart. A result is written to a one-entry output register
// once the frame's last byte has passed the front register and token queue.
// Nothing needs clearing, so bytes are taken from the first cycle out of reset.
module ascii_length_framed_xy_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic signed [15:0] o_x_centi,
    output logic signed [15:0] o_y_centi,
    output logic [1:0]         o_frame_status
);
    import alxy_pkg::*;

    logic w_f_valid, w_f_ready;
    t_tok w_f_tok;
    logic w_b_valid, w_b_ready;
    t_tok w_b_tok;

    alxy_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_tok_valid (w_f_valid),
        .i_tok_ready (w_f_ready),
        .o_tok       (w_f_tok)
    );

    alxy_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_tok   (w_f_tok),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_pop_tok    (w_b_tok)
    );

    alxy_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (w_b_valid),
        .o_tok_ready    (w_b_ready),
        .i_tok          (w_b_tok),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_x_centi      (o_x_centi),
        .o_y_centi      (o_y_centi),
        .o_frame_status (o_frame_status)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for ascii_length_framed_xy_parser.
// Depends on alxy_pkg; random framed traffic is checked against a behavioural
// parser fed every accepted byte, and the directed rows against their table.
`timescale 1ns / 100ps

module testbench;
    import alxy_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         st;
    } t_xy;

    typedef struct {
        string text;
        bit    typed;
        t_xy   res;
    } t_row;

    typedef enum logic [1:0] {HUNT_M, HUNT_P, LEN_DIGIT, BODY} t_phase;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_rx_valid = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_res_ready = 1'b0;
    logic               o_rx_ready;
    logic               o_res_valid;
    logic signed [15:0] o_x_centi;
    logic signed [15:0] o_y_centi;
    logic [1:0]         o_frame_status;

    ascii_length_framed_xy_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_x_centi      (o_x_centi),
        .o_y_centi      (o_y_centi),
        .o_frame_status (o_frame_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // An empty text stands for a single NUL byte, which a string cannot hold.
    t_row directed [4] = '{
        '{"", 1'b0, '0},
        '{"MP0000", 1'b1, '{16'sd0, 16'sd0, ST_FEW}},
        '{"MMP0\377", 1'b1, '{16'sd0, 16'sd0, ST_BAD_LEN}},
        '{"MP0010,,-99999,7", 1'b1, '{16'sh8000, 16'sd7, ST_OK}}
    };

    int unsigned send_pct [3] = '{18, 52, 0};
    int unsigned recv_pct [3] = '{52, 18, 0};
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 52;

    t_xy        pending_xy [$];
    logic [7:0] burst [$];
    logic [7:0] frame_body [$];
    int         n_err = 0;
    int         cycle_count = 0;
    int         sent_bytes = 0;

    // Parser state as seen from the byte stream.
    t_phase      p_phase = HUNT_M;
    int unsigned p_len_cnt = 0;
    int unsigned p_len = 0;
    int unsigned p_left = 0;
    int unsigned p_field = 0;
    int unsigned p_acc = 0;
    bit          p_neg = 1'b0;
    bit          p_dig = 1'b0;
    bit          p_has = 1'b0;
    bit          p_stop = 1'b0;
    bit          p_xerr = 1'b0;
    logic [15:0] p_x = '0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_err++;
    endtask

    task automatic put_burst(input logic [7:0] b);
        burst = {burst, b};
    endtask

    task automatic put_body(input logic [7:0] b);
        frame_body = {frame_body, b};
    endtask

    function automatic logic [15:0] clamp_centi(int unsigned mag, bit neg);
        logic [15:0] m16;
        if (neg) begin
            if (mag > 32768) mag = 32768;
            m16 = mag[15:0];
            return -m16;
        end
        if (mag > 32767) mag = 32767;
        return mag[15:0];
    endfunction

    task automatic clear_field();
        p_acc  = 0;
        p_neg  = 1'b0;
        p_dig  = 1'b0;
        p_has  = 1'b0;
        p_stop = 1'b0;
    endtask

    task automatic finish_frame(output t_xy r);
        logic [1:0] st;
        if (p_field < 2) st = ST_FEW;
        else if (p_field == 2) st = (p_has && !p_dig) ? ST_NO_DIG : ST_FEW;
        else if (p_xerr) st = ST_NO_DIG;
        else if (p_field == 3 && !p_has) st = ST_FEW;
        else if (!p_dig) st = ST_NO_DIG;
        else st = ST_OK;
        r.st = st;
        r.x  = (st == ST_OK) ? p_x : 16'd0;
        r.y  = (st == ST_OK) ? clamp_centi(p_acc, p_neg) : 16'd0;
        p_phase = HUNT_M;
    endtask

    task automatic advance_parser(input logic [7:0] c, output bit got, output t_xy r);
        got = 1'b0;
        r   = '0;
        case (p_phase)
            HUNT_M: begin
                if (c == CH_M) p_phase = HUNT_P;
            end
            HUNT_P: begin
                if (c == CH_P) begin
                    p_phase   = LEN_DIGIT;
                    p_len_cnt = 0;
                    p_len     = 0;
                end else if (c != CH_M) begin
                    p_phase = HUNT_M;
                end
            end
            LEN_DIGIT: begin
                if (c < CH_ZERO || c > CH_NINE) begin
                    got     = 1'b1;
                    r.st    = ST_BAD_LEN;
                    p_phase = HUNT_M;
                end else begin
                    p_len = p_len * 10 + (c - CH_ZERO);
                    p_len_cnt++;
                    if (p_len_cnt == LEN_DIGITS) begin
                        p_len_cnt = 0;
                        p_field   = 0;
                        p_xerr    = 1'b0;
                        p_x       = '0;
                        clear_field();
                        p_left = p_len;
                        if (p_left == 0) begin
                            got = 1'b1;
                            finish_frame(r);
                        end else begin
                            p_phase = BODY;
                        end
                    end
                end
            end
            BODY: begin
                if (c == CH_COMMA) begin
                    if (p_field == 2) begin
                        p_x    = clamp_centi(p_acc, p_neg);
                        p_xerr = !p_dig;
                        clear_field();
                        p_field = 3;
                    end else if (p_field == 3) begin
                        // The y value stays put; later fields are only counted.
                        p_field = 4;
                    end else if (p_field < 2) begin
                        clear_field();
                        p_field++;
                    end
                end else if (p_field == 2 || p_field == 3) begin
                    if (!p_stop) begin
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            p_acc = p_acc * 10 + (c - CH_ZERO);
                            if (p_acc > 32768) p_acc = 32768;
                            p_dig = 1'b1;
                        end else if (!p_has && (c == CH_PLUS || c == CH_MINUS)) begin
                            p_neg = (c == CH_MINUS);
                        end else begin
                            p_stop = 1'b1;
                        end
                    end
                    p_has = 1'b1;
                end
                p_left--;
                if (p_left == 0) begin
                    got = 1'b1;
                    finish_frame(r);
                end
            end
        endcase
    endtask

    // Any byte but a digit or a comma; a sign now and then.
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) return $urandom_range(1) ? CH_PLUS : CH_MINUS;
        if (b == CH_COMMA || (b >= CH_ZERO && b <= CH_NINE)) b = b ^ 8'h40;
        return b;
    endfunction

    task automatic add_number();
        string bound [5] = '{"32767", "32768", "32769", "99999", "0"};
        string s;
        int    r;
        r = $urandom_range(9);
        if (r == 0) return;
        if ($urandom_range(2) == 0) put_body($urandom_range(1) ? CH_MINUS : CH_PLUS);
        if (r < 4) begin
            s = bound[$urandom_range(4)];
            for (int i = 0; i < s.len(); i++) put_body(s[i]);
        end else begin
            repeat ($urandom_range(5)) put_body(8'(CH_ZERO + $urandom_range(9)));
        end
        // Digits after a stray character must be ignored.
        if ($urandom_range(3) == 0) begin
            put_body(junk_byte());
            repeat ($urandom_range(2)) put_body(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    task automatic make_frame();
        int kind;
        int nfld;
        int len;
        int bad_pos;
        burst.delete();
        frame_body.delete();
        kind = $urandom_range(99);
        put_burst(CH_M);
        if (kind < 8) begin
            put_burst(junk_byte());
            return;
        end
        if ($urandom_range(3) == 0) put_burst(CH_M);
        put_burst(CH_P);
        nfld = $urandom_range(6);
        for (int f = 0; f < nfld; f++) begin
            if (f > 0) put_body(CH_COMMA);
            if (f == 2 || f == 3) add_number();
            else repeat ($urandom_range(3)) put_body(junk_byte());
        end
        if ($urandom_range(7) == 0) put_body(CH_COMMA);
        len = frame_body.size();
        // A length that disagrees with the body cuts the frame short or runs on.
        if ($urandom_range(9) == 0) len = $urandom_range(len + 3);
        bad_pos = (kind < 15) ? $urandom_range(LEN_DIGITS - 1) : LEN_DIGITS;
        for (int i = 0; i < LEN_DIGITS; i++) begin
            if (i == bad_pos) put_burst(junk_byte());
            else put_burst(8'(CH_ZERO + (len / (10 ** (LEN_DIGITS - 1 - i))) % 10));
        end
        foreach (frame_body[i]) put_burst(frame_body[i]);
    endtask

    task automatic send_rx(input logic [7:0] b, input bit typed, input t_xy typed_res);
        bit  got;
        t_xy r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        advance_parser(b, got, r);
        if (typed && !got) report_mismatch("directed row ends without a predicted result");
        if (got) begin
            if (typed) r = typed_res;
            pending_xy = {pending_xy, r};
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].text.len() == 0) begin
                send_rx(8'h00, directed[k].typed, directed[k].res);
            end else begin
                for (int i = 0; i < directed[k].text.len(); i++)
                    send_rx(directed[k].text[i],
                            directed[k].typed && i == directed[k].text.len() - 1,
                            directed[k].res);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            while (sent_bytes < (ph + 1) * RANDOM_ITEMS / 3) begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)), 1'b0, '0);
                make_frame();
                foreach (burst[i]) send_rx(burst[i], 1'b0, '0);
                sent_bytes += burst.size();
            end
        end

        i_rx_valid <= 1'b0;
        while (pending_xy.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge i_clk) begin : result_sink
        t_xy want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_xy.size() == 0) begin
                report_mismatch("result transfer with no result pending");
            end else begin
                want = pending_xy[0];
                pending_xy.delete(0);
                if (o_x_centi !== want.x)
                    report_mismatch($sformatf("x_centi %0d, expected %0d", o_x_centi, want.x));
                if (o_y_centi !== want.y)
                    report_mismatch($sformatf("y_centi %0d, expected %0d", o_y_centi, want.y));
                if (o_frame_status !== want.st)
                    report_mismatch($sformatf("frame_status %0d, expected %0d",
                                              o_frame_status, want.st));
            end
        end
        i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
